// ===== design/ebdc_pkg.sv =====
`default_nettype none
package ebdc_pkg;

  localparam int CFG_TW   = 16;  // width of the millisecond config registers
  localparam int DUTY_W   = 13;
  localparam int EFFECT_W = 16;
  localparam int DELTA_W  = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_BRIGHT = 2'd1;
  localparam logic [1:0] MODE_EFFECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX     = 3'd5;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CFG_TW-1:0] long_press_ms;
    logic [CFG_TW-1:0] debounce_ms;
    logic [CFG_TW-1:0] effect_settle_ms;
    logic [DUTY_W-1:0] duty_step;
    logic [DUTY_W-1:0] duty_min;
    logic [DUTY_W-1:0] duty_max;
  } ebdc_cfg_t;

  // one classified tick handed from the button front end to the back end
  typedef struct packed {
    logic                       short_ev;
    logic                       long_ev;
    logic signed [DELTA_W-1:0]  delta;
  } ebdc_evt_t;

endpackage
`default_nettype wire

// ===== design/ebdc_if.sv =====
`default_nettype none
interface ebdc_in_if;
  logic              valid;
  logic              ready;
  logic              button_pressed;
  logic signed [5:0] count_delta;

  modport source (output valid, button_pressed, count_delta, input ready);
  modport sink (input valid, button_pressed, count_delta, output ready);
endinterface

interface ebdc_out_if;
  logic               valid;
  logic               ready;
  logic [12:0]        pwm_duty;
  logic [1:0]         mode;
  logic signed [15:0] effect_value;
  logic               short_press_seen;
  logic               long_press_seen;
  logic               rotation_applied;

  modport source (output valid, pwm_duty, mode, effect_value, short_press_seen,
                  long_press_seen, rotation_applied, input ready);
  modport sink (input valid, pwm_duty, mode, effect_value, short_press_seen,
                long_press_seen, rotation_applied, output ready);
endinterface

interface ebdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/ebdc_front.sv =====
`default_nettype none
module ebdc_front
  import ebdc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  ebdc_in_if.sink        in_if,
  input  wire ebdc_cfg_t cfg,
  input  wire logic      q_full,
  output logic           push,
  output ebdc_evt_t      push_evt
);

  localparam int CMP_W = (TIMER_BITS > CFG_TW) ? TIMER_BITS : CFG_TW;

  logic [TIMER_BITS-1:0] tse_r, tse_nxt;
  logic [TIMER_BITS-1:0] tsp_r, tsp_nxt;
  logic prev_r, prev_nxt;
  logic held_r, held_nxt;
  logic released_r, released_nxt;
  logic handled_r, handled_nxt;
  logic short_ev, long_ev;

  assign in_if.ready = !q_full;
  assign push        = in_if.valid && !q_full;

  always_comb begin
    tse_nxt      = (tse_r == '1) ? tse_r : tse_r + 1'b1;
    tsp_nxt      = (tsp_r == '1) ? tsp_r : tsp_r + 1'b1;
    held_nxt     = held_r;
    released_nxt = released_r;
    handled_nxt  = handled_r;
    short_ev     = 1'b0;
    long_ev      = 1'b0;

    if (in_if.button_pressed != prev_r &&
        CMP_W'(tse_nxt) >= CMP_W'(cfg.debounce_ms)) begin
      tse_nxt = '0;
      if (in_if.button_pressed) begin
        tsp_nxt      = '0;
        held_nxt     = 1'b1;
        handled_nxt  = 1'b0;
        released_nxt = 1'b0;
      end else begin
        held_nxt     = 1'b0;
        released_nxt = 1'b1;
      end
    end
    prev_nxt = in_if.button_pressed;

    if (!handled_nxt) begin
      if (held_nxt && CMP_W'(tsp_nxt) >= CMP_W'(cfg.long_press_ms)) begin
        long_ev     = 1'b1;
        handled_nxt = 1'b1;
      end
      if (!handled_nxt && released_nxt) begin
        if (CMP_W'(tsp_nxt) < CMP_W'(cfg.long_press_ms)) begin
          short_ev = 1'b1;
        end else begin
          long_ev = 1'b1;
        end
        handled_nxt = 1'b1;
      end
    end
  end

  assign push_evt.short_ev = short_ev;
  assign push_evt.long_ev  = long_ev;
  assign push_evt.delta    = in_if.count_delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tse_r      <= '1;
      tsp_r      <= '0;
      prev_r     <= 1'b0;
      held_r     <= 1'b0;
      released_r <= 1'b0;
      handled_r  <= 1'b1;
    end else if (push) begin
      tse_r      <= tse_nxt;
      tsp_r      <= tsp_nxt;
      prev_r     <= prev_nxt;
      held_r     <= held_nxt;
      released_r <= released_nxt;
      handled_r  <= handled_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ebdc_queue.sv =====
`default_nettype none
module ebdc_queue
  import ebdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire ebdc_evt_t push_evt,
  input  wire logic      pop,
  output logic           full,
  output logic           empty,
  output ebdc_evt_t      head
);

  ebdc_evt_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_evt;
    end
  end

endmodule
`default_nettype wire

// ===== design/ebdc_back.sv =====
`default_nettype none
module ebdc_back
  import ebdc_pkg::*;
#(
  parameter int TIMER_BITS = 16,
  parameter int ACCUM_BITS = 13
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ebdc_cfg_t cfg,
  input  wire logic      q_empty,
  input  wire ebdc_evt_t head,
  output logic           pop,
  ebdc_out_if.source     out_if
);

  localparam int CMP_W = (TIMER_BITS > CFG_TW) ? TIMER_BITS : CFG_TW;
  localparam int SW    = ACCUM_BITS + 1;
  localparam int PW    = ACCUM_BITS + DUTY_W + 1;
  localparam int NW    = PW + 1;
  localparam logic signed [SW-1:0] ACC_HI = SW'((1 << (ACCUM_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] ACC_LO = SW'(-(1 << (ACCUM_BITS - 1)));

  logic [1:0]                   mode_r, mode_nxt;
  logic [DUTY_W-1:0]            stored_r, stored_nxt;
  logic [DUTY_W-1:0]            duty_r, duty_nxt;
  logic signed [EFFECT_W-1:0]   effect_r, effect_nxt;
  logic signed [ACCUM_BITS-1:0] acc_r, acc_nxt;
  logic                         pend_r, pend_nxt;
  logic [TIMER_BITS-1:0]        tsr_r, tsr_nxt;
  logic                         out_valid_r;
  logic                         applied;

  logic signed [SW-1:0]  sum;
  logic [CFG_TW-1:0]     settle;
  logic                  rot_ev;
  logic signed [PW-1:0]  prod;
  logic signed [NW-1:0]  nd;

  assign pop = !q_empty && (!out_valid_r || out_if.ready);

  always_comb begin
    mode_nxt   = mode_r;
    stored_nxt = stored_r;
    duty_nxt   = duty_r;
    effect_nxt = effect_r;
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    rot_ev     = 1'b0;
    applied    = 1'b0;
    tsr_nxt    = (tsr_r == '1) ? tsr_r : tsr_r + 1'b1;
    sum        = SW'(acc_r) + SW'(head.delta);
    settle     = (mode_r == MODE_EFFECT) ? cfg.effect_settle_ms : '0;

    // count rotation against the mode at the start of the tick
    if (head.delta != '0 && mode_r != MODE_OFF) begin
      if (sum > ACC_HI) begin
        acc_nxt = ACC_HI[ACCUM_BITS-1:0];
      end else if (sum < ACC_LO) begin
        acc_nxt = ACC_LO[ACCUM_BITS-1:0];
      end else begin
        acc_nxt = sum[ACCUM_BITS-1:0];
      end
      pend_nxt = 1'b1;
      tsr_nxt  = '0;
    end
    if (pend_nxt && CMP_W'(tsr_nxt) >= CMP_W'(settle)) begin
      pend_nxt = 1'b0;
      rot_ev   = 1'b1;
    end

    if (head.long_ev) begin
      mode_nxt = MODE_OFF;
      duty_nxt = '0;
    end
    if (head.short_ev) begin
      unique case (mode_nxt)
        MODE_OFF: begin
          mode_nxt = MODE_BRIGHT;
          if (stored_nxt == '0) begin
            stored_nxt = cfg.duty_min;
          end
          duty_nxt = stored_nxt;
        end
        MODE_BRIGHT: mode_nxt = MODE_EFFECT;
        default:     mode_nxt = MODE_BRIGHT;
      endcase
    end

    prod = PW'(acc_nxt) * PW'($signed({1'b0, cfg.duty_step}));
    nd   = NW'(prod) + $signed(NW'(stored_nxt));
    if (nd < $signed(NW'(cfg.duty_min))) begin
      nd = $signed(NW'(cfg.duty_min));
    end
    if (nd > $signed(NW'(cfg.duty_max))) begin
      nd = $signed(NW'(cfg.duty_max));
    end

    if (rot_ev) begin
      if (mode_nxt == MODE_BRIGHT || mode_nxt == MODE_EFFECT) begin
        stored_nxt = nd[DUTY_W-1:0];
        duty_nxt   = nd[DUTY_W-1:0];
        if (mode_nxt == MODE_EFFECT) begin
          effect_nxt = effect_r + EFFECT_W'(acc_nxt);
        end
        applied = 1'b1;
      end
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      stored_r    <= '0;
      duty_r      <= '0;
      effect_r    <= '0;
      acc_r       <= '0;
      pend_r      <= 1'b0;
      tsr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        mode_r   <= mode_nxt;
        stored_r <= stored_nxt;
        duty_r   <= duty_nxt;
        effect_r <= effect_nxt;
        acc_r    <= acc_nxt;
        pend_r   <= pend_nxt;
        tsr_r    <= tsr_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, loaded whenever an item leaves the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      out_if.pwm_duty         <= duty_nxt;
      out_if.mode             <= mode_nxt;
      out_if.effect_value     <= effect_nxt;
      out_if.short_press_seen <= head.short_ev;
      out_if.long_press_seen  <= head.long_ev;
      out_if.rotation_applied <= applied;
    end
  end

  assign out_if.valid = out_valid_r;

endmodule
`default_nettype wire

// ===== design/encoder_button_dimmer_controller_top.sv =====
// Rotary-encoder push-button dimmer controller.
// in_if: one item per millisecond tick, carrying the button level and the
//   signed encoder count change. out_if: exactly one result item per tick,
//   with the PWM duty, mode, effect value and the press/rotation event flags.
// cfg_if: register writes (index 0..5), always ready; write only while idle.
// A front end debounces the button and classifies presses, pushes each tick
//   into a two-entry queue, and a back end counts rotation, applies events
//   and loads the result register.
// Throughput: one item per cycle while out_if.ready stays high. Stages: two
//   register stages (queue, then result register), which each result passes
//   through in that order before out_if.valid rises. The back end's
//   multiply-add-clamp of the duty sets the clock period.
// When out_if.ready is low while a result is valid, the result register holds,
//   the queue fills and in_if.ready drops once both queue entries are taken.
// Reset (rst_n low, synchronous): mode off, duty and accumulators zero,
//   queue and result register empty, config registers to their defaults.
`default_nettype none
module encoder_button_dimmer_controller_top
  import ebdc_pkg::*;
#(
  parameter int TIMER_BITS = 16,
  parameter int ACCUM_BITS = 13
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ebdc_in_if.sink    in_if,
  ebdc_out_if.source out_if,
  ebdc_cfg_if.sink   cfg_if
);

  ebdc_cfg_t cfg_r;
  logic      push, pop, q_full, q_empty;
  ebdc_evt_t push_evt, head;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms    <= 16'd500;
      cfg_r.debounce_ms      <= 16'd50;
      cfg_r.effect_settle_ms <= 16'd150;
      cfg_r.duty_step        <= 13'd500;
      cfg_r.duty_min         <= 13'd100;
      cfg_r.duty_max         <= 13'd8191;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_LONG_PRESS:    cfg_r.long_press_ms    <= cfg_if.data;
        CFG_DEBOUNCE:      cfg_r.debounce_ms      <= cfg_if.data;
        CFG_EFFECT_SETTLE: cfg_r.effect_settle_ms <= cfg_if.data;
        CFG_DUTY_STEP:     cfg_r.duty_step        <= cfg_if.data[DUTY_W-1:0];
        CFG_DUTY_MIN:      cfg_r.duty_min         <= cfg_if.data[DUTY_W-1:0];
        CFG_DUTY_MAX:      cfg_r.duty_max         <= cfg_if.data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  ebdc_front #(
    .TIMER_BITS(TIMER_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_evt (push_evt)
  );

  ebdc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  ebdc_back #(
    .TIMER_BITS(TIMER_BITS),
    .ACCUM_BITS(ACCUM_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

// ===== bench/dimmer_monitor.sv =====
module dimmer_monitor
  import ebdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ebdc_in_if          in_if,
  ebdc_out_if         out_if,
  ebdc_cfg_if         cfg_if,
  output int unsigned failures,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [1:0]          mode;
    logic [EFFECT_W-1:0] effect;
    logic                short_seen;
    logic                long_seen;
    logic                rot_seen;
  } tick_result_t;

  localparam logic [CFG_TW-1:0] TIMER_TOP = '1;
  localparam int ROT_HI = 4095;
  localparam int ROT_LO = -4096;

  ebdc_cfg_t         regs;
  logic [1:0]        mode_q;
  logic [DUTY_W-1:0] duty_store, duty_out;
  logic [EFFECT_W-1:0] effect_sum;
  int                rot_sum;
  logic              rot_wait, btn_last, held, released, handled;
  logic [CFG_TW-1:0] t_rot, t_edge, t_press;

  tick_result_t expected_ticks[$];
  int unsigned  fail_count = 0;
  int unsigned  queued = 0;

  assign failures    = fail_count;
  assign outstanding = queued;

  function automatic logic [CFG_TW-1:0] sat_inc(input logic [CFG_TW-1:0] t);
    return (t == TIMER_TOP) ? t : t + 1'b1;
  endfunction

  function automatic int field_diff(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic reset_model();
    regs       = '{long_press_ms: 500, debounce_ms: 50, effect_settle_ms: 150,
                   duty_step: 500, duty_min: 100, duty_max: 8191};
    mode_q     = MODE_OFF;
    duty_store = '0;
    duty_out   = '0;
    effect_sum = '0;
    rot_sum    = 0;
    rot_wait   = 1'b0;
    t_rot      = '0;
    t_edge     = TIMER_TOP;
    t_press    = '0;
    btn_last   = 1'b0;
    held       = 1'b0;
    released   = 1'b0;
    handled    = 1'b1;
  endtask

  // One millisecond tick: timers, button edges, press class, rotation, then events.
  function automatic tick_result_t advance_tick(input logic b, input logic signed [5:0] d);
    tick_result_t      r;
    logic [1:0]        mode_at_start;
    logic [CFG_TW-1:0] settle;
    longint            nd;
    int                s;
    logic              short_ev, long_ev, rot_ev;
    r             = '0;
    short_ev      = 1'b0;
    long_ev       = 1'b0;
    rot_ev        = 1'b0;
    mode_at_start = mode_q;

    t_edge  = sat_inc(t_edge);
    t_press = sat_inc(t_press);
    t_rot   = sat_inc(t_rot);

    if (b != btn_last && t_edge >= regs.debounce_ms) begin
      t_edge = '0;
      if (b) begin
        t_press  = '0;
        held     = 1'b1;
        handled  = 1'b0;
        released = 1'b0;
      end else begin
        held     = 1'b0;
        released = 1'b1;
      end
    end
    btn_last = b;

    if (!handled) begin
      if (held && t_press >= regs.long_press_ms) begin
        long_ev = 1'b1;
        handled = 1'b1;
      end
      if (!handled && released) begin
        if (t_press < regs.long_press_ms) short_ev = 1'b1;
        else long_ev = 1'b1;
        handled = 1'b1;
      end
    end

    // counts while off are dropped, but a pending rotation still confirms
    if (d != 0 && mode_at_start != MODE_OFF) begin
      s = rot_sum + int'(d);
      if (s > ROT_HI) s = ROT_HI;
      if (s < ROT_LO) s = ROT_LO;
      rot_sum  = s;
      rot_wait = 1'b1;
      t_rot    = '0;
    end
    if (rot_wait) begin
      settle = (mode_at_start == MODE_EFFECT) ? regs.effect_settle_ms : '0;
      if (t_rot >= settle) begin
        rot_wait = 1'b0;
        rot_ev   = 1'b1;
      end
    end

    if (long_ev) begin
      mode_q   = MODE_OFF;
      duty_out = '0;
    end
    if (short_ev) begin
      if (mode_q == MODE_OFF) begin
        mode_q = MODE_BRIGHT;
        if (duty_store == '0) duty_store = regs.duty_min;
        duty_out = duty_store;
      end else if (mode_q == MODE_BRIGHT) begin
        mode_q = MODE_EFFECT;
      end else begin
        mode_q = MODE_BRIGHT;
      end
    end
    if (rot_ev) begin
      if (mode_q == MODE_BRIGHT || mode_q == MODE_EFFECT) begin
        nd = longint'(duty_store) + longint'(rot_sum) * longint'(regs.duty_step);
        // min first, then max, so an inverted pair settles on duty_max
        if (nd < longint'(regs.duty_min)) nd = longint'(regs.duty_min);
        if (nd > longint'(regs.duty_max)) nd = longint'(regs.duty_max);
        duty_store = nd[DUTY_W-1:0];
        duty_out   = duty_store;
        if (mode_q == MODE_EFFECT) effect_sum = effect_sum + 16'(rot_sum);
        r.rot_seen = 1'b1;
      end
      rot_sum = 0;
    end

    r.duty       = duty_out;
    r.mode       = mode_q;
    r.effect     = effect_sum;
    r.short_seen = short_ev;
    r.long_seen  = long_ev;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      reset_model();
      expected_ticks.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_LONG_PRESS:    regs.long_press_ms    = cfg_if.data;
          CFG_DEBOUNCE:      regs.debounce_ms      = cfg_if.data;
          CFG_EFFECT_SETTLE: regs.effect_settle_ms = cfg_if.data;
          CFG_DUTY_STEP:     regs.duty_step        = cfg_if.data[DUTY_W-1:0];
          CFG_DUTY_MIN:      regs.duty_min         = cfg_if.data[DUTY_W-1:0];
          CFG_DUTY_MAX:      regs.duty_max         = cfg_if.data[DUTY_W-1:0];
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_ticks.size() == 0) begin
          $error("result item with no tick waiting for it");
          errs++;
        end else begin
          want = expected_ticks.pop_front();
          errs += field_diff("pwm_duty", want.duty, out_if.pwm_duty);
          errs += field_diff("mode", want.mode, out_if.mode);
          errs += field_diff("effect_value", longint'($signed(want.effect)),
                             longint'(out_if.effect_value));
          errs += field_diff("short_press_seen", want.short_seen, out_if.short_press_seen);
          errs += field_diff("long_press_seen", want.long_seen, out_if.long_press_seen);
          errs += field_diff("rotation_applied", want.rot_seen, out_if.rotation_applied);
        end
      end
      if (in_if.valid && in_if.ready)
        expected_ticks.push_back(advance_tick(in_if.button_pressed, in_if.count_delta));
    end
    fail_count <= fail_count + errs;
    queued     <= expected_ticks.size();
  end

endmodule

// ===== bench/encoder_button_dimmer_controller_top_test.sv =====
module encoder_button_dimmer_controller_top_test;
  import ebdc_pkg::*;

  localparam int PHASES = 7;
  localparam int PHASE_TICKS = 280;
  localparam int DIR_LEN = 26;
  localparam logic signed [DELTA_W-1:0] DELTA_HI = 6'sd21;
  localparam logic signed [DELTA_W-1:0] DELTA_LO = -6'sd21;

  logic clk, rst_n;
  int unsigned failures, outstanding;
  int in_idle_pct, out_idle_pct, ticks_sent;
  logic btn_level;

  ebdc_in_if  in_if();
  ebdc_out_if out_if();
  ebdc_cfg_if cfg_if();

  encoder_button_dimmer_controller_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  dimmer_monitor mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_if      (cfg_if),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // bounce, short presses, brightness and effect rotation, then a long press
  // with a rotation still settling, which is dropped once off
  logic dir_btn [DIR_LEN] = '{0, 1, 0, 1, 1, 0, 0, 0, 1, 1, 0, 0, 0,
                              0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 1, 0};
  logic signed [DELTA_W-1:0] dir_delta [DIR_LEN] =
    '{DELTA_HI, 0, 0, 0, 0, 0, DELTA_LO, DELTA_HI, 0, 0, 0, 5, -3,
      0, 0, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0, -1};

  ebdc_cfg_t dir_cfg = '{long_press_ms: 4, debounce_ms: 2, effect_settle_ms: 6,
                         duty_step: 100, duty_min: 50, duty_max: 400};
  ebdc_cfg_t phase_cfg [PHASES];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("encoder_button_dimmer_controller_top_test: errors");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic logic signed [DELTA_W-1:0] rand_delta();
    return DELTA_W'(int'($urandom_range(42)) - 21);
  endfunction

  function automatic logic signed [DELTA_W-1:0] side_delta();
    return ($urandom_range(3) == 0) ? rand_delta() : '0;
  endfunction

  task automatic send_tick(input logic b, input logic signed [DELTA_W-1:0] d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.button_pressed <= b;
    in_if.count_delta    <= d;
    do @(posedge clk); while (!in_if.ready);
    ticks_sent++;
    btn_level = b;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic apply_config(input ebdc_cfg_t c);
    write_reg(CFG_LONG_PRESS, c.long_press_ms);
    write_reg(CFG_DEBOUNCE, c.debounce_ms);
    write_reg(CFG_EFFECT_SETTLE, c.effect_settle_ms);
    write_reg(CFG_DUTY_STEP, 16'(c.duty_step));
    write_reg(CFG_DUTY_MIN, 16'(c.duty_min));
    write_reg(CFG_DUTY_MAX, 16'(c.duty_max));
    cfg_if.valid <= 1'b0;
  endtask

  // drop valid and hold until every tick has produced its result
  task automatic settle_out();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic press_gesture(input ebdc_cfg_t c);
    int lp, db, hold, gap, sel;
    lp  = int'(c.long_press_ms);
    db  = int'(c.debounce_ms);
    sel = $urandom_range(3);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_tick(~btn_level, side_delta());
    hold = $urandom_range(1, (lp > 40) ? 40 : lp);
    // hold right at the threshold: long while held, long on release, or just short
    if (sel == 0 && lp <= 400) hold = lp + $urandom_range(0, 2);
    else if (sel == 1 && lp <= 400) hold = (lp > 1) ? lp - 1 : 1;
    repeat (hold) send_tick(1'b1, side_delta());
    gap = $urandom_range(1, (db > 57) ? 60 : db + 3);
    repeat (gap) send_tick(1'b0, side_delta());
  endtask

  task automatic spin_gesture(input ebdc_cfg_t c);
    int settle, quiet;
    logic signed [DELTA_W-1:0] dir;
    settle = int'(c.effect_settle_ms);
    if (settle >= 250 && $urandom_range(4) == 0) begin
      // long one-way spin that can saturate the count accumulator
      dir = $urandom_range(1) ? DELTA_HI : DELTA_LO;
      repeat ($urandom_range(200, 240))
        send_tick(btn_level, ($urandom_range(7) == 0) ? rand_delta() : dir);
    end else begin
      repeat ($urandom_range(1, 6)) send_tick(btn_level, rand_delta());
    end
    quiet = $urandom_range(0, (settle > 38) ? 40 : settle + 2);
    repeat (quiet) send_tick(btn_level, '0);
  endtask

  initial begin
    int start;
    phase_cfg[0] = '{long_press_ms: 12, debounce_ms: 3, effect_settle_ms: 6,
                     duty_step: 37, duty_min: 100, duty_max: 5000};
    phase_cfg[1] = '{long_press_ms: 1, debounce_ms: 0, effect_settle_ms: 0,
                     duty_step: 8191, duty_min: 0, duty_max: 8191};
    phase_cfg[2] = '{long_press_ms: 30, debounce_ms: 65535, effect_settle_ms: 65535,
                     duty_step: 1, duty_min: 8191, duty_max: 8191};
    phase_cfg[3] = '{long_press_ms: 8, debounce_ms: 1, effect_settle_ms: 400,
                     duty_step: 3, duty_min: 6000, duty_max: 200};
    phase_cfg[4] = '{long_press_ms: 65535, debounce_ms: 2, effect_settle_ms: 0,
                     duty_step: 0, duty_min: 0, duty_max: 0};
    phase_cfg[5] = '{long_press_ms: 20, debounce_ms: 4, effect_settle_ms: 10,
                     duty_step: 250, duty_min: 1000, duty_max: 7000};
    phase_cfg[6] = '{long_press_ms: 500, debounce_ms: 50, effect_settle_ms: 150,
                     duty_step: 500, duty_min: 100, duty_max: 8191};

    in_idle_pct  = 20;
    out_idle_pct = 74;
    ticks_sent   = 0;
    btn_level    = 1'b0;
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.button_pressed <= 1'b0;
    in_if.count_delta    <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_LONG_PRESS;
    cfg_if.data          <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset debounce rejects the quick release and re-press
    send_tick(1'b1, '0);
    send_tick(1'b0, '0);
    send_tick(1'b1, '0);
    settle_out();

    apply_config(dir_cfg);
    for (int i = 0; i < DIR_LEN; i++) send_tick(dir_btn[i], dir_delta[i]);
    settle_out();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        in_idle_pct  = 74;
        out_idle_pct = 20;
      end else if (p == 5) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      apply_config(phase_cfg[p]);
      start = ticks_sent;
      while (ticks_sent - start < PHASE_TICKS) begin
        case ($urandom_range(9))
          0, 1, 2, 3: press_gesture(phase_cfg[p]);
          4, 5, 6, 7: spin_gesture(phase_cfg[p]);
          default:
            repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(1)), rand_delta());
        endcase
      end
      settle_out();
    end

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("encoder_button_dimmer_controller_top_test: clean");
    end else begin
      $display("encoder_button_dimmer_controller_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ebdc_pkg.sv
design/ebdc_if.sv
design/ebdc_front.sv
design/ebdc_queue.sv
design/ebdc_back.sv
design/encoder_button_dimmer_controller_top.sv
bench/dimmer_monitor.sv
bench/encoder_button_dimmer_controller_top_test.sv
